// File: rtl/bmce_pkg.sv
// Package for the bipartite matching critical-edge block.
// Holds the transaction payload types and the request and register codes.
// No dependencies.
package bmce_pkg;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam int CFG_WIDTH = 8;
  localparam int CELL_WIDTH = 7;
  localparam int OUT_WIDTH = 8;

  typedef struct packed {
    logic                  req_type;
    logic [CELL_WIDTH-1:0] cell_row;
    logic [CELL_WIDTH-1:0] cell_col;
  } in_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] matching_size;
    logic [OUT_WIDTH-1:0] critical_count;
  } out_t;

endpackage

// File: rtl/bmce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the adjacency rows, the column match tables and the search stack.
// No dependencies.
module bmce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bipartite_matching_critical_edges.sv
// Bipartite matching with critical-edge count. An add transaction stores one board cell.
// An evaluate transaction runs Kuhn augmenting-path searches, first for each row, then
// once per matched column with that edge removed, and returns matching_size and
// critical_count; the board is then cleared at once. One shared column-test unit examines
// one column per cycle while scanning, and each stack move refetches the adjacency row. An
// evaluate runs up to (rows+cols) searches. The block stalls its input while an add or
// evaluate is in flight.
// Depends on bmce_pkg and bmce_ram.
module bipartite_matching_critical_edges #(
  parameter int MAX_SIDE = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bmce_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bmce_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bmce_pkg::out_t                out_data
);

  import bmce_pkg::*;

  localparam int IW = $clog2(MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE + 1);
  localparam int SW = IW + CW;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_ADD_WR    = 13'b0000000000010,
    S_P1_START  = 13'b0000000000100,
    S_ROW_RD    = 13'b0000000001000,
    S_ROW_LATCH = 13'b0000000010000,
    S_SCAN      = 13'b0000000100000,
    S_PUSH      = 13'b0000001000000,
    S_POP_WT    = 13'b0000010000000,
    S_COMMIT_RD = 13'b0000100000000,
    S_COMMIT_WR = 13'b0001000000000,
    S_P2_START  = 13'b0010000000000,
    S_P2_OWNER  = 13'b0100000000000,
    S_FINISH    = 13'b1000000000000
  } state_t;

  state_t state;

  logic [CFG_WIDTH-1:0] rows_cfg;
  logic [CFG_WIDTH-1:0] cols_cfg;
  logic [CW-1:0]        nrow;
  logic [CW-1:0]        ncol;

  logic [MAX_SIDE-1:0] row_valid;
  logic [MAX_SIDE-1:0] col_valid;
  logic [MAX_SIDE-1:0] saved_valid;
  logic [MAX_SIDE-1:0] visited;
  logic [MAX_SIDE-1:0] dirty;
  logic [MAX_SIDE-1:0] rowbits;

  logic [IW-1:0] add_row;
  logic [IW-1:0] add_col;
  logic [IW-1:0] top_row;
  logic [CW-1:0] top_col;
  logic [CW-1:0] depth;
  logic [CW-1:0] r_idx;
  logic [CW-1:0] c_idx;
  logic [CW-1:0] size_cnt;
  logic [CW-1:0] crit_cnt;
  logic [IW-1:0] rem_row;
  logic [IW-1:0] rem_col;
  logic          phase2;
  logic          sel_scratch;

  logic [IW-1:0]       v;
  logic [IW-1:0]       c_sel;
  logic [MAX_SIDE-1:0] one;

  // RAM ports
  logic                adj_we;
  logic [IW-1:0]       adj_waddr;
  logic [MAX_SIDE-1:0] adj_wdata;
  logic [IW-1:0]       adj_raddr;
  logic [MAX_SIDE-1:0] adj_rdata;

  logic          mw_en;
  logic [IW-1:0] mw_addr;
  logic [IW-1:0] mw_data;
  logic [IW-1:0] m_raddr;
  logic [IW-1:0] main_rdata;
  logic [IW-1:0] scr_rdata;
  logic [IW-1:0] match_rd;

  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [SW-1:0] st_wdata;
  logic [IW-1:0] st_raddr;
  logic [SW-1:0] st_rdata;
  logic [IW-1:0] stk_row;
  logic [CW-1:0] stk_col;

  logic [MAX_SIDE-1:0] row_mask;

  assign nrow = (int'(rows_cfg) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(rows_cfg);
  assign ncol = (int'(cols_cfg) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(cols_cfg);

  assign one      = {{(MAX_SIDE-1){1'b0}}, 1'b1};
  assign v        = top_col[IW-1:0];
  assign c_sel    = c_idx[IW-1:0];
  assign match_rd = sel_scratch ? scr_rdata : main_rdata;
  assign stk_row  = st_rdata[SW-1:CW];
  assign stk_col  = st_rdata[CW-1:0];
  assign in_stall = (state != S_IDLE);

  // Drop the edge under test from the fetched row during the critical pass
  assign row_mask = (phase2 && top_row == rem_row) ? ~(one << rem_col) : '1;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = add_row;
    adj_wdata = (row_valid[add_row] ? adj_rdata : '0) | (one << add_col);
    adj_raddr = top_row;
    mw_en     = 1'b0;
    mw_addr   = v;
    mw_data   = top_row;
    m_raddr   = v;
    st_we     = 1'b0;
    st_waddr  = depth[IW-1:0];
    st_wdata  = {top_row, top_col};
    st_raddr  = IW'(depth - 1'b1);
    case (state)
      S_IDLE: begin
        adj_raddr = IW'(in_data.cell_row);
      end
      S_ADD_WR: begin
        adj_we = 1'b1;
      end
      S_SCAN: begin
        if (top_col < ncol && rowbits[v] && !visited[v] && !col_valid[v]) begin
          mw_en = 1'b1;
        end
      end
      S_PUSH: begin
        st_we = 1'b1;
      end
      S_COMMIT_WR: begin
        mw_en   = 1'b1;
        mw_addr = stk_col[IW-1:0];
        mw_data = stk_row;
      end
      S_P2_START: begin
        m_raddr = c_sel;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rows_cfg  <= CFG_WIDTH'(128);
      cols_cfg  <= CFG_WIDTH'(128);
      row_valid <= '0;
      col_valid <= '0;
      out_valid <= 1'b0;
      phase2    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          rows_cfg <= cfg_data;
        end else begin
          cols_cfg <= cfg_data;
        end
      end
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.req_type == REQ_EVAL) begin
              r_idx     <= '0;
              size_cnt  <= '0;
              crit_cnt  <= '0;
              col_valid <= '0;
              phase2    <= 1'b0;
              state     <= S_P1_START;
            end else if (int'(in_data.cell_row) < MAX_SIDE &&
                         int'(in_data.cell_col) < MAX_SIDE) begin
              add_row <= IW'(in_data.cell_row);
              add_col <= IW'(in_data.cell_col);
              state   <= S_ADD_WR;
            end
          end
        end
        S_ADD_WR: begin
          row_valid[add_row] <= 1'b1;
          state              <= S_IDLE;
        end
        S_P1_START: begin
          if (r_idx >= nrow) begin
            saved_valid <= col_valid;
            phase2      <= 1'b1;
            c_idx       <= '0;
            state       <= S_P2_START;
          end else begin
            visited <= '0;
            top_row <= r_idx[IW-1:0];
            top_col <= '0;
            depth   <= '0;
            state   <= S_ROW_RD;
          end
        end
        S_ROW_RD: begin
          state <= S_ROW_LATCH;
        end
        S_ROW_LATCH: begin
          rowbits <= (row_valid[top_row] ? adj_rdata : '0) & row_mask;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (top_col >= ncol) begin
            if (depth == '0) begin
              // search failed
              if (phase2) begin
                crit_cnt <= crit_cnt + 1'b1;
                c_idx    <= c_idx + 1'b1;
                state    <= S_P2_START;
              end else begin
                r_idx <= r_idx + 1'b1;
                state <= S_P1_START;
              end
            end else begin
              depth <= depth - 1'b1;
              state <= S_POP_WT;
            end
          end else if (rowbits[v] && !visited[v]) begin
            visited[v] <= 1'b1;
            if (!col_valid[v]) begin
              col_valid[v] <= 1'b1;
              if (phase2) begin
                dirty[v] <= 1'b1;
              end
              if (depth == '0) begin
                if (phase2) begin
                  c_idx <= c_idx + 1'b1;
                  state <= S_P2_START;
                end else begin
                  size_cnt <= size_cnt + 1'b1;
                  r_idx    <= r_idx + 1'b1;
                  state    <= S_P1_START;
                end
              end else begin
                state <= S_COMMIT_RD;
              end
            end else begin
              sel_scratch <= phase2 & dirty[v];
              state       <= S_PUSH;
            end
          end else begin
            top_col <= top_col + 1'b1;
          end
        end
        S_PUSH: begin
          depth   <= depth + 1'b1;
          top_row <= match_rd;
          top_col <= '0;
          state   <= S_ROW_RD;
        end
        S_POP_WT: begin
          top_row <= stk_row;
          top_col <= stk_col + 1'b1;
          state   <= S_ROW_RD;
        end
        S_COMMIT_RD: begin
          state <= S_COMMIT_WR;
        end
        S_COMMIT_WR: begin
          col_valid[stk_col[IW-1:0]] <= 1'b1;
          if (phase2) begin
            dirty[stk_col[IW-1:0]] <= 1'b1;
          end
          depth <= depth - 1'b1;
          if (depth == CW'(1)) begin
            if (phase2) begin
              c_idx <= c_idx + 1'b1;
              state <= S_P2_START;
            end else begin
              size_cnt <= size_cnt + 1'b1;
              r_idx    <= r_idx + 1'b1;
              state    <= S_P1_START;
            end
          end else begin
            state <= S_COMMIT_RD;
          end
        end
        S_P2_START: begin
          if (c_idx >= ncol) begin
            state <= S_FINISH;
          end else begin
            // restore the saved matching with the column under test freed
            col_valid   <= saved_valid & ~(one << c_sel);
            dirty       <= '0;
            visited     <= '0;
            sel_scratch <= 1'b0;
            if (saved_valid[c_sel]) begin
              state <= S_P2_OWNER;
            end else begin
              c_idx <= c_idx + 1'b1;
            end
          end
        end
        S_P2_OWNER: begin
          rem_row <= match_rd;
          rem_col <= c_sel;
          top_row <= match_rd;
          top_col <= '0;
          depth   <= '0;
          state   <= S_ROW_RD;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_data.matching_size  <= OUT_WIDTH'(size_cnt);
            out_data.critical_count <= OUT_WIDTH'(crit_cnt);
            out_valid               <= 1'b1;
            row_valid               <= '0;
            phase2                  <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bmce_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  bmce_ram #(.WIDTH(IW), .DEPTH(MAX_SIDE)) u_match_main (
    .clk   (clk),
    .we    (mw_en & ~phase2),
    .waddr (mw_addr),
    .wdata (mw_data),
    .raddr (m_raddr),
    .rdata (main_rdata)
  );

  bmce_ram #(.WIDTH(IW), .DEPTH(MAX_SIDE)) u_match_scratch (
    .clk   (clk),
    .we    (mw_en & phase2),
    .waddr (mw_addr),
    .wdata (mw_data),
    .raddr (m_raddr),
    .rdata (scr_rdata)
  );

  bmce_ram #(.WIDTH(SW), .DEPTH(MAX_SIDE)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for bipartite_matching_critical_edges.
// Streams board cells and evaluate requests and checks each result against a
// scoreboard that recomputes the matching. Depends on bmce_pkg and the block.
`timescale 1ns / 1ps

module testbench;
  import bmce_pkg::*;

  localparam int SIDE = 128;
  localparam int ITEMS = 1850;

  class matching_checker;
    bit adj[SIDE][SIDE];
    bit col_taken[SIDE];
    int col_owner[SIDE];
    bit seen[SIDE];
    int frame_row[SIDE+1];
    int frame_col[SIDE+1];
    int rows_cfg = 128;
    int cols_cfg = 128;
    out_t expected_counts[$];
    int failures = 0;

    function bit augment(int start, int ncol);
      int sp;
      int v;
      int k;
      bit pushed;
      sp = 1;
      frame_row[0] = start;
      frame_col[0] = 0;
      while (sp > 0) begin
        v = frame_col[sp-1];
        pushed = 0;
        while (v < ncol) begin
          if (adj[frame_row[sp-1]][v] && !seen[v]) begin
            seen[v] = 1;
            frame_col[sp-1] = v;
            if (!col_taken[v]) begin
              for (k = sp - 1; k >= 0; k--) begin
                col_taken[frame_col[k]] = 1;
                col_owner[frame_col[k]] = frame_row[k];
              end
              return 1;
            end
            if (sp < SIDE + 1) begin
              frame_row[sp] = col_owner[v];
              frame_col[sp] = 0;
              sp++;
              pushed = 1;
              break;
            end
          end
          v++;
        end
        if (!pushed) begin
          sp--;
          if (sp > 0) frame_col[sp-1]++;
        end
      end
      return 0;
    endfunction

    function void note_config(logic idx, int value);
      if (idx == CFG_ROWS) rows_cfg = value;
      else cols_cfg = value;
    endfunction

    function void note_request(in_t t);
      int nrow;
      int ncol;
      int size;
      int crit;
      int owner;
      bit keep_taken[SIDE];
      int keep_owner[SIDE];
      out_t res;
      if (t.req_type == REQ_ADD) begin
        adj[t.cell_row][t.cell_col] = 1;
        return;
      end
      nrow = rows_cfg > SIDE ? SIDE : rows_cfg;
      ncol = cols_cfg > SIDE ? SIDE : cols_cfg;
      size = 0;
      crit = 0;
      foreach (col_taken[i]) col_taken[i] = 0;
      for (int r = 0; r < nrow; r++) begin
        foreach (seen[i]) seen[i] = 0;
        if (augment(r, ncol)) size++;
      end
      keep_taken = col_taken;
      keep_owner = col_owner;
      for (int c = 0; c < ncol; c++) begin
        col_taken = keep_taken;
        col_owner = keep_owner;
        if (col_taken[c]) begin
          owner = col_owner[c];
          adj[owner][c] = 0;
          col_taken[c] = 0;
          foreach (seen[i]) seen[i] = 0;
          if (!augment(owner, ncol)) crit++;
          adj[owner][c] = 1;
        end
      end
      foreach (adj[i, j]) adj[i][j] = 0;
      res.matching_size = size[7:0];
      res.critical_count = crit[7:0];
      expected_counts = {expected_counts, res};
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_counts.size() == 0) begin
        $error("unexpected result: matching_size %0d critical_count %0d",
               got.matching_size, got.critical_count);
        failures++;
        return;
      end
      want = expected_counts.pop_front();
      if (got.matching_size !== want.matching_size) begin
        $error("matching_size: expected %0d, actual %0d", want.matching_size,
               got.matching_size);
        failures++;
      end
      if (got.critical_count !== want.critical_count) begin
        $error("critical_count: expected %0d, actual %0d", want.critical_count,
               got.critical_count);
        failures++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = CFG_ROWS;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_t out_data;

  matching_checker sb = new();
  int sent = 0;
  bit quiet = 0;
  int stall_left = 0;

  bipartite_matching_critical_edges u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  initial begin
    #60_000_000;
    $display("FAIL bipartite_matching_critical_edges");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver back-pressure in bursts; no new burst starts once the run goes quiet.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_stall = (stall_left > 0);
  end

  task automatic send_req(in_t t);
    int gap;
    @(negedge clk);
    in_valid = 1;
    in_data = t;
    do @(posedge clk); while (in_stall);
    sb.note_request(t);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_cell(int r, int c);
    in_t t;
    t.req_type = REQ_ADD;
    t.cell_row = r[6:0];
    t.cell_col = c[6:0];
    send_req(t);
  endtask

  task automatic evaluate();
    in_t t;
    t.req_type = REQ_EVAL;
    t.cell_row = 7'($urandom_range(0, 127));
    t.cell_col = 7'($urandom_range(0, 127));
    send_req(t);
  endtask

  // Hold until every result is back, then let an in-flight add finish.
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value[7:0];
    sb.note_config(idx, value & 255);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_sides(int r, int c);
    drain();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLS, c);
  endtask

  initial begin
    int nr;
    int nc;
    int cells;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Full-size board with corner cells, then an empty board.
    add_cell(0, 0);
    add_cell(127, 127);
    add_cell(0, 127);
    add_cell(127, 0);
    add_cell(5, 5);
    evaluate();
    evaluate();
    // Zero rows: empty side.
    set_sides(0, 5);
    add_cell(1, 1);
    evaluate();
    // Oversized values clamp to the full side.
    set_sides(255, 200);
    add_cell(3, 4);
    add_cell(4, 4);
    add_cell(100, 4);
    evaluate();
    // Single cell side with a duplicate add.
    set_sides(1, 1);
    add_cell(0, 0);
    add_cell(0, 0);
    add_cell(9, 0);
    evaluate();
    // Complete 3x2 graph: no critical edge.
    set_sides(3, 2);
    for (int r = 0; r < 3; r++) for (int c = 0; c < 2; c++) add_cell(r, c);
    evaluate();

    while (sent < ITEMS) begin
      if (sent > ITEMS * 85 / 100) quiet = 1;
      if ($urandom_range(0, 29) == 0) begin
        nr = $urandom_range(100, 128);
        nc = $urandom_range(100, 128);
      end else begin
        nr = $urandom_range(1, 8);
        nc = $urandom_range(1, 8);
      end
      set_sides(nr, nc);
      repeat ($urandom_range(1, 4)) begin
        cells = $urandom_range(0, 14);
        repeat (cells) begin
          if ($urandom_range(0, 9) == 0)
            add_cell($urandom_range(0, 127), $urandom_range(0, 127));
          else
            add_cell($urandom_range(0, (nr > 128 ? 128 : nr) - 1),
                     $urandom_range(0, (nc > 128 ? 128 : nc) - 1));
        end
        evaluate();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.expected_counts.size() != 0) begin
      $error("%0d results never arrived", sb.expected_counts.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("PASS bipartite_matching_critical_edges");
    end else begin
      $display("FAIL bipartite_matching_critical_edges");
    end
    $finish;
  end

endmodule
